/* hdl/m4inv_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m4inv_pkg: shared types and constants for the 4x4 matrix inverse
// Sequencer states, default fixed-point format and submatrix index helper.
// ----------------------------------------------------------------------------
package m4inv_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int WORD_BITS_DEF = 32;
	localparam int EPS_BITS      = 17;
	localparam logic [EPS_BITS-1:0] EPS_RESET = 17'd1;

	typedef enum logic [3:0] {
		S_LOAD,
		S_FETCH_B,
		S_FETCH_A,
		S_MUL,
		S_ACC,
		S_COF,
		S_ABS,
		S_CMP,
		S_DIV_INIT,
		S_DIV,
		S_ROUND,
		S_EMIT
	} seq_state_t;

	// k-th surviving index (0..2) once index x is struck out of 0..3
	function automatic logic [1:0] skip_idx(input logic [1:0] x, input logic [1:0] k);
		skip_idx = (k < x) ? k : k + 2'd1;
	endfunction

endpackage

/* hdl/matrix4_inverse_cofactor.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix4_inverse_cofactor: 4x4 fixed-point inverse by the adjugate
// Loads 16 elements, forms all cofactors and the determinant on one shared
// shift-add multiplier, then divides each transposed cofactor by the
// determinant on one restoring divider, rounding and saturating the result.
// ----------------------------------------------------------------------------
//  channel  | handshake            | payload
//  ---------+----------------------+-------------------------------------------
//  input    | in_valid / in_stall  | element_value
//  output   | out_valid / out_stall| inverse_element, invertible, saturated,
//           |                      | last_of_run
//  config   | cfg_valid / cfg_ready| det_epsilon
//
//  Loading accepts one element per cycle. After the 16th element the block
//  runs 148 multiplies on the shared multiplier, then one division per
//  inverse element in the divider; in_stall is high throughout.
//  The singular case ends after the determinant check with one item.
//  A stalled output item holds; the sequencer waits on it before the next.
//  Reset clears the sequencer, load count, output valid and sets epsilon to 1.
// ----------------------------------------------------------------------------
module matrix4_inverse_cofactor #(
	parameter int FRAC_BITS = m4inv_pkg::FRAC_BITS_DEF,
	parameter int WORD_BITS = m4inv_pkg::WORD_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// element input
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic signed [WORD_BITS-1:0]        element_value,
	// result output
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic signed [WORD_BITS-1:0]        inverse_element,
	output logic                               invertible,
	output logic                               saturated,
	output logic                               last_of_run,
	// configuration
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [m4inv_pkg::EPS_BITS-1:0]     det_epsilon
);

	localparam int W   = WORD_BITS;
	localparam int F   = FRAC_BITS;
	localparam int CW  = 3 * W + 4;            // cofactor width
	localparam int DW  = 4 * W + 6;            // determinant / product width
	localparam int NB  = CW - 1 + 2 * F;       // numerator magnitude bits
	localparam int MCW = $clog2(W);
	localparam int DCW = $clog2(NB);
	localparam int SW  = DW + 3 * F + m4inv_pkg::EPS_BITS;

	m4inv_pkg::seq_state_t state_q, state_d;

	logic [W-1:0]  mat_q [16];
	logic [CW-1:0] cof_q [16];
	logic [3:0]    load_cnt_q;
	logic [m4inv_pkg::EPS_BITS-1:0] eps_q;

	logic [3:0]    ci_q;          // cofactor / det column / output index
	logic [1:0]    term_q;
	logic [1:0]    op_q;
	logic          det_ph_q;
	logic          sing_q;
	logic [MCW-1:0] mcnt_q;
	logic [DCW-1:0] dcnt_q;

	logic [W-1:0]  a_q;
	logic [CW-1:0] b_q;
	logic [DW-1:0] acc_q;
	logic [2*W:0]  d_q;
	logic [CW-1:0] m_q;
	logic [DW-1:0] det_q;
	logic [DW-1:0] dabs_q;
	logic [NB-1:0] num_q;
	logic [DW-1:0] rem_q;
	logic [W:0]    quo_q;
	logic          ovf_q;
	logic          neg_q;
	logic [W-1:0]  res_q;
	logic          rsat_q;

	logic          out_valid_q;
	logic [W-1:0]  out_elem_q;
	logic          out_inv_q, out_sat_q, out_last_q;

	// ------------------------------------------------------------------
	// operand addressing
	logic [1:0] row, col, r0, r1, r2, cx, cy, ct;
	logic [3:0] rd_addr;
	logic [W-1:0] rd_elem;
	logic [3:0] cof_addr;
	logic [CW-1:0] cof_rd;

	assign row = ci_q[3:2];
	assign col = ci_q[1:0];
	assign r0  = m4inv_pkg::skip_idx(row, 2'd0);
	assign r1  = m4inv_pkg::skip_idx(row, 2'd1);
	assign r2  = m4inv_pkg::skip_idx(row, 2'd2);
	assign cx  = m4inv_pkg::skip_idx(col, (term_q == 2'd0) ? 2'd1 : 2'd0);
	assign cy  = m4inv_pkg::skip_idx(col, (term_q == 2'd2) ? 2'd1 : 2'd2);
	assign ct  = m4inv_pkg::skip_idx(col, term_q);

	always_comb begin
		rd_addr = {r1, cx};
		if (det_ph_q) begin
			rd_addr = {2'd0, col};
		end else if (state_q == m4inv_pkg::S_FETCH_B) begin
			rd_addr = (op_q == 2'd0) ? {r2, cy} : {r2, cx};
		end else begin
			case (op_q)
				2'd0:    rd_addr = {r1, cx};
				2'd1:    rd_addr = {r1, cy};
				default: rd_addr = {r0, ct};
			endcase
		end
	end

	assign rd_elem  = mat_q[rd_addr];
	// det reads row 0 cofactors; divider reads transposed (j,i)
	assign cof_addr = det_ph_q ? {2'd0, col} : {ci_q[1:0], ci_q[3:2]};
	assign cof_rd   = cof_q[cof_addr];

	// ------------------------------------------------------------------
	// shared arithmetic
	logic [DW-1:0] b_ext, addend, acc_d;
	logic [DW:0]   rem_t;
	logic          rem_ge;
	logic [SW-1:0] eps_sh, dabs_sh;
	logic          rnd;
	logic [W+1:0]  lim, qr, qval, qneg;
	logic          qsat;
	logic [CW-1:0] cof_abs;
	logic          out_free;

	assign b_ext  = {{(DW-CW){b_q[CW-1]}}, b_q};
	assign addend = a_q[W-1] ? ((mcnt_q == '0) ? (~b_ext + DW'(1)) : b_ext) : '0;
	assign acc_d  = {acc_q[DW-2:0], 1'b0} + addend;

	assign rem_t  = {rem_q, num_q[NB-1]};
	assign rem_ge = rem_t >= {1'b0, dabs_q};

	assign eps_sh  = SW'(eps_q) << (3 * F);
	assign dabs_sh = SW'(dabs_q);

	assign rnd  = {rem_q, 1'b0} >= {1'b0, dabs_q};
	assign lim  = {2'b00, neg_q, {(W-1){~neg_q}}};
	assign qr   = {1'b0, quo_q} + (W+2)'(rnd);
	assign qsat = ovf_q || (qr > lim);
	assign qval = qsat ? lim : qr;
	assign qneg = ~qval + (W+2)'(1);

	assign cof_abs  = cof_rd[CW-1] ? (~cof_rd + CW'(1)) : cof_rd;
	assign out_free = !out_valid_q || !out_stall;

	// ------------------------------------------------------------------
	// sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= m4inv_pkg::S_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and handshake outputs
	always_comb begin
		state_d  = state_q;
		in_stall = 1'b1;
		unique case (state_q)
			m4inv_pkg::S_LOAD: begin
				in_stall = 1'b0;
				if (in_valid && load_cnt_q == 4'hF) state_d = m4inv_pkg::S_FETCH_B;
			end
			m4inv_pkg::S_FETCH_B: state_d = m4inv_pkg::S_FETCH_A;
			m4inv_pkg::S_FETCH_A: state_d = m4inv_pkg::S_MUL;
			m4inv_pkg::S_MUL: begin
				if (mcnt_q == MCW'(W - 1)) state_d = m4inv_pkg::S_ACC;
			end
			m4inv_pkg::S_ACC: begin
				if (det_ph_q) begin
					state_d = (col == 2'd3) ? m4inv_pkg::S_ABS : m4inv_pkg::S_FETCH_B;
				end else if (op_q == 2'd2 && term_q == 2'd2) begin
					state_d = m4inv_pkg::S_COF;
				end else begin
					state_d = m4inv_pkg::S_FETCH_B;
				end
			end
			m4inv_pkg::S_COF:      state_d = m4inv_pkg::S_FETCH_B;
			m4inv_pkg::S_ABS:      state_d = m4inv_pkg::S_CMP;
			m4inv_pkg::S_CMP: begin
				state_d = (dabs_sh <= eps_sh) ? m4inv_pkg::S_EMIT : m4inv_pkg::S_DIV_INIT;
			end
			m4inv_pkg::S_DIV_INIT: state_d = m4inv_pkg::S_DIV;
			m4inv_pkg::S_DIV: begin
				if (dcnt_q == DCW'(NB - 1)) state_d = m4inv_pkg::S_ROUND;
			end
			m4inv_pkg::S_ROUND:    state_d = m4inv_pkg::S_EMIT;
			m4inv_pkg::S_EMIT: begin
				if (out_free) begin
					state_d = (sing_q || ci_q == 4'hF) ? m4inv_pkg::S_LOAD
						: m4inv_pkg::S_DIV_INIT;
				end
			end
			default: state_d = m4inv_pkg::S_LOAD;
		endcase
	end

	// ------------------------------------------------------------------
	// control counters and flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_cnt_q <= '0;
			eps_q      <= m4inv_pkg::EPS_RESET;
			ci_q       <= '0;
			term_q     <= '0;
			op_q       <= '0;
			det_ph_q   <= 1'b0;
			sing_q     <= 1'b0;
			mcnt_q     <= '0;
			dcnt_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) eps_q <= det_epsilon;
			// output valid: set on a new item, cleared once taken
			if (state_q == m4inv_pkg::S_EMIT && out_free) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
			unique case (state_q)
				m4inv_pkg::S_LOAD: begin
					if (in_valid) load_cnt_q <= load_cnt_q + 4'd1;
					ci_q     <= '0;
					term_q   <= '0;
					op_q     <= '0;
					det_ph_q <= 1'b0;
					sing_q   <= 1'b0;
				end
				m4inv_pkg::S_FETCH_A: mcnt_q <= '0;
				m4inv_pkg::S_MUL:     mcnt_q <= mcnt_q + MCW'(1);
				m4inv_pkg::S_ACC: begin
					if (det_ph_q) begin
						if (col != 2'd3) ci_q <= ci_q + 4'd1;
					end else if (op_q == 2'd2) begin
						op_q <= '0;
						if (term_q != 2'd2) term_q <= term_q + 2'd1;
					end else begin
						op_q <= op_q + 2'd1;
					end
				end
				m4inv_pkg::S_COF: begin
					ci_q   <= ci_q + 4'd1;
					term_q <= '0;
					op_q   <= '0;
					if (ci_q == 4'hF) det_ph_q <= 1'b1;
				end
				m4inv_pkg::S_CMP: begin
					ci_q     <= '0;
					det_ph_q <= 1'b0;
					sing_q   <= dabs_sh <= eps_sh;
				end
				m4inv_pkg::S_DIV_INIT: dcnt_q <= '0;
				m4inv_pkg::S_DIV:      dcnt_q <= dcnt_q + DCW'(1);
				m4inv_pkg::S_EMIT: begin
					if (out_free) begin
						if (!sing_q && ci_q != 4'hF) ci_q <= ci_q + 4'd1;
					end
				end
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			m4inv_pkg::S_LOAD: begin
				if (in_valid) mat_q[load_cnt_q] <= element_value;
				m_q   <= '0;
				det_q <= '0;
			end
			m4inv_pkg::S_FETCH_B: begin
				if (det_ph_q) b_q <= cof_rd;
				else if (op_q == 2'd2) b_q <= {{(CW-2*W-1){d_q[2*W]}}, d_q};
				else b_q <= {{(CW-W){rd_elem[W-1]}}, rd_elem};
			end
			m4inv_pkg::S_FETCH_A: begin
				a_q   <= rd_elem;
				acc_q <= '0;
			end
			m4inv_pkg::S_MUL: begin
				acc_q <= acc_d;
				a_q   <= {a_q[W-2:0], 1'b0};
			end
			m4inv_pkg::S_ACC: begin
				if (det_ph_q) begin
					det_q <= det_q + acc_q;
				end else begin
					case (op_q)
						2'd0:    d_q <= acc_q[2*W:0];
						2'd1:    d_q <= d_q - acc_q[2*W:0];
						default: m_q <= (term_q == 2'd1) ? m_q - acc_q[CW-1:0]
							: m_q + acc_q[CW-1:0];
					endcase
				end
			end
			m4inv_pkg::S_COF: begin
				cof_q[ci_q] <= (row[0] ^ col[0]) ? (~m_q + CW'(1)) : m_q;
				m_q <= '0;
			end
			m4inv_pkg::S_ABS: dabs_q <= det_q[DW-1] ? (~det_q + DW'(1)) : det_q;
			m4inv_pkg::S_DIV_INIT: begin
				num_q <= {cof_abs[CW-2:0], {(2*F){1'b0}}};
				neg_q <= cof_rd[CW-1] ^ det_q[DW-1];
				rem_q <= '0;
				quo_q <= '0;
				ovf_q <= 1'b0;
			end
			m4inv_pkg::S_DIV: begin
				rem_q <= rem_ge ? DW'(rem_t - {1'b0, dabs_q}) : rem_t[DW-1:0];
				quo_q <= {quo_q[W-1:0], rem_ge};
				ovf_q <= ovf_q | quo_q[W];
				num_q <= {num_q[NB-2:0], 1'b0};
			end
			m4inv_pkg::S_ROUND: begin
				res_q  <= neg_q ? qneg[W-1:0] : qval[W-1:0];
				rsat_q <= qsat;
			end
			m4inv_pkg::S_EMIT: begin
				if (out_free) begin
					out_elem_q <= sing_q ? '0 : res_q;
					out_inv_q  <= !sing_q;
					out_sat_q  <= !sing_q && rsat_q;
					out_last_q <= sing_q || ci_q == 4'hF;
				end
			end
			default: ;
		endcase
	end

	assign out_valid       = out_valid_q;
	assign inverse_element = out_elem_q;
	assign invertible      = out_inv_q;
	assign saturated       = out_sat_q;
	assign last_of_run     = out_last_q;
	assign cfg_ready       = 1'b1;

	// ------------------------------------------------------------------
	// checks
	a_sing_item: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !invertible) |-> (last_of_run && !saturated && inverse_element == '0))
		else $error("singular item malformed");

	a_sat_inv: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && saturated) |-> invertible)
		else $error("saturation flagged on singular item");

	a_det_start: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(det_ph_q) |-> (ci_q == 4'd0 && state_q == m4inv_pkg::S_FETCH_B))
		else $error("determinant pass started off column 0");

	a_stall_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == m4inv_pkg::S_DIV) |-> (in_stall && !det_ph_q))
		else $error("input open during division");

endmodule

/* sim/m4inv_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m4inv_checker: result predictor and scoreboard for the 4x4 inverse
// Watches the element, result and epsilon channels, works out the expected
// inverse of each complete matrix with exact wide arithmetic, and compares
// every accepted result item against the oldest expected one.
// ----------------------------------------------------------------------------
module m4inv_checker (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	input  logic                                   in_stall,
	input  logic signed [m4inv_pkg::WORD_BITS_DEF-1:0] element_value,
	input  logic                                   out_valid,
	input  logic                                   out_stall,
	input  logic signed [m4inv_pkg::WORD_BITS_DEF-1:0] inverse_element,
	input  logic                                   invertible,
	input  logic                                   saturated,
	input  logic                                   last_of_run,
	input  logic                                   cfg_valid,
	input  logic                                   cfg_ready,
	input  logic [m4inv_pkg::EPS_BITS-1:0]         det_epsilon,
	output int                                     errors,
	output int                                     pending
);

	localparam int F = m4inv_pkg::FRAC_BITS_DEF;
	localparam int W = m4inv_pkg::WORD_BITS_DEF;

	// wide enough for determinant and shifted cofactors without overflow
	typedef logic signed [287:0] wide_t;

	typedef struct {
		logic [W-1:0] value;
		logic         inv;
		logic         sat;
		logic         last;
	} inv_item_t;

	inv_item_t            inv_expected_q[$];
	logic signed [W-1:0]  mat_store[16];
	logic [3:0]           fill_slot;
	logic [m4inv_pkg::EPS_BITS-1:0] eps_reg;

	initial errors = 0;

	task automatic report(input string what);
		$display("[%0t] MISMATCH: %s", $time, what);
		errors++;
	endtask

	function automatic wide_t mat_at(input int r, input int c);
		return wide_t'(mat_store[r * 4 + c]);
	endfunction

	// signed cofactor via 3x3 minor split into 2x2 determinants
	function automatic wide_t cofactor_of(input int row, input int col);
		wide_t s[3][3];
		wide_t m;
		int i, j;
		i = 0;
		for (int r = 0; r < 4; r++) begin
			if (r == row)
				continue;
			j = 0;
			for (int c = 0; c < 4; c++) begin
				if (c == col)
					continue;
				s[i][j] = mat_at(r, c);
				j++;
			end
			i++;
		end
		m = s[0][0] * (s[1][1] * s[2][2] - s[1][2] * s[2][1])
		  - s[0][1] * (s[1][0] * s[2][2] - s[1][2] * s[2][0])
		  + s[0][2] * (s[1][0] * s[2][1] - s[1][1] * s[2][0]);
		return ((row + col) & 1) ? -m : m;
	endfunction

	task automatic predict_inverse();
		wide_t     cof[4][4];
		wide_t     det, dabs, num, q, rem, lim;
		logic      neg;
		inv_item_t it;
		det = '0;
		for (int i = 0; i < 4; i++)
			for (int j = 0; j < 4; j++)
				cof[i][j] = cofactor_of(i, j);
		for (int j = 0; j < 4; j++)
			det = det + mat_at(0, j) * cof[0][j];
		dabs = (det < 0) ? -det : det;
		if (dabs <= (wide_t'(eps_reg) <<< (3 * F))) begin
			it = '{value: '0, inv: 1'b0, sat: 1'b0, last: 1'b1};
			inv_expected_q.push_back(it);
			return;
		end
		// element (i,j) of the inverse is cofactor (j,i) over det
		for (int i = 0; i < 4; i++) begin
			for (int j = 0; j < 4; j++) begin
				num = cof[j][i] <<< (2 * F);
				neg = (num < 0) != (det < 0);
				if (num < 0)
					num = -num;
				q   = num / dabs;
				rem = num % dabs;
				if ((rem <<< 1) >= dabs)
					q = q + 1;
				lim = neg ? (wide_t'(1) <<< (W - 1)) : ((wide_t'(1) <<< (W - 1)) - 1);
				it.sat = (q > lim);
				if (it.sat)
					q = lim;
				if (neg)
					q = -q;
				it.value = q[W-1:0];
				it.inv   = 1'b1;
				it.last  = (i == 3 && j == 3);
				inv_expected_q.push_back(it);
			end
		end
	endtask

	// track config, elements and results
	always @(posedge clk or negedge arst_n) begin
		inv_item_t e;
		if (!arst_n) begin
			fill_slot = '0;
			eps_reg   = m4inv_pkg::EPS_RESET;
			inv_expected_q.delete();
			pending  <= 0;
		end else begin
			if (cfg_valid && cfg_ready)
				eps_reg = det_epsilon;
			if (in_valid && !in_stall) begin
				mat_store[fill_slot] = element_value;
				fill_slot = fill_slot + 4'd1;
				if (fill_slot == 4'd0)
					predict_inverse();
			end
			if (out_valid && !out_stall) begin
				if (inv_expected_q.size() == 0) begin
					report("result item with nothing expected");
				end else begin
					e = inv_expected_q.pop_front();
					if (inverse_element !== e.value)
						report($sformatf("inverse_element got %h want %h",
							inverse_element, e.value));
					if (invertible !== e.inv)
						report($sformatf("invertible got %b want %b", invertible, e.inv));
					if (saturated !== e.sat)
						report($sformatf("saturated got %b want %b", saturated, e.sat));
					if (last_of_run !== e.last)
						report($sformatf("last_of_run got %b want %b", last_of_run, e.last));
				end
			end
			pending <= inv_expected_q.size();
		end
	end

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: top-level bench for the 4x4 matrix inverse
// Streams directed and random matrices under varying idle patterns and
// epsilon settings; the checker predicts and compares every result item.
// ----------------------------------------------------------------------------
module tb;

	localparam int W  = m4inv_pkg::WORD_BITS_DEF;
	localparam int EB = m4inv_pkg::EPS_BITS;
	localparam logic signed [W-1:0] ONE = 32'sh0001_0000;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	logic signed [W-1:0] element_value;
	logic                out_valid;
	logic                out_stall;
	logic signed [W-1:0] inverse_element;
	logic                invertible;
	logic                saturated;
	logic                last_of_run;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [EB-1:0]       det_epsilon;
	int                  errors;
	int                  pending;
	int                  send_gap_pct;
	int                  recv_stall_pct;
	logic signed [W-1:0] mat[16];

	matrix4_inverse_cofactor dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .element_value(element_value),
		.out_valid(out_valid), .out_stall(out_stall),
		.inverse_element(inverse_element), .invertible(invertible),
		.saturated(saturated), .last_of_run(last_of_run),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .det_epsilon(det_epsilon)
	);

	m4inv_checker chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .element_value(element_value),
		.out_valid(out_valid), .out_stall(out_stall),
		.inverse_element(inverse_element), .invertible(invertible),
		.saturated(saturated), .last_of_run(last_of_run),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .det_epsilon(det_epsilon),
		.errors(errors), .pending(pending)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// receiver back-pressure
	always @(posedge clk)
		out_stall <= ($urandom_range(99) < recv_stall_pct);

	task automatic send_element(input logic signed [W-1:0] v);
		while ($urandom_range(99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid      <= 1'b1;
		element_value <= v;
		do
			@(posedge clk);
		while (in_stall);
	endtask

	task automatic send_matrix();
		for (int k = 0; k < 16; k++)
			send_element(mat[k]);
	endtask

	// epsilon write once the block has drained
	task automatic write_epsilon(input logic [EB-1:0] v);
		in_valid <= 1'b0;
		// let the checker register the last accepted element first
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (64) @(posedge clk);
		cfg_valid   <= 1'b1;
		det_epsilon <= v;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic signed [W-1:0] small_val();
		return $signed($urandom_range(1 << 20)) - (1 << 19);
	endfunction

	// random matrix of one of several flavours
	task automatic make_matrix(input int kind);
		for (int k = 0; k < 16; k++) begin
			case (kind)
				0: mat[k] = small_val();
				1: mat[k] = (k % 5 == 0) ? small_val() * 8 + 4 * ONE : small_val() >>> 3;
				2: mat[k] = $signed($urandom);
				3: mat[k] = $signed($urandom_range(511)) - 256;
				default: mat[k] = $signed($urandom_range(8)) * ONE - 4 * ONE;
			endcase
		end
		// flavour with a repeated row is exactly singular
		if (kind == 4)
			for (int c = 0; c < 4; c++)
				mat[12 + c] = mat[4 + c];
	endtask

	task automatic run_phase(input int n, input int gap, input int stall);
		send_gap_pct   = gap;
		recv_stall_pct = stall;
		for (int m = 0; m < n; m++) begin
			make_matrix($urandom_range(4));
			send_matrix();
		end
	endtask

	initial begin
		in_valid       = 1'b0;
		element_value  = '0;
		out_stall      = 1'b0;
		cfg_valid      = 1'b0;
		det_epsilon    = '0;
		send_gap_pct   = 0;
		recv_stall_pct = 0;
		arst_n         = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: identity with zero epsilon, then field extremes
		write_epsilon('0);
		for (int k = 0; k < 16; k++)
			mat[k] = (k % 5 == 0) ? ONE : '0;
		send_matrix();
		mat = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0000_0001, 32'shFFFF_FFFF,
			32'sh0000_0000, 32'sh7FFF_FFFF, 32'shFFFF_0000, 32'sh0001_0000,
			32'sh0000_8000, 32'sh0000_0000, 32'sh8000_0000, 32'sh0000_0003,
			32'shFFFF_FFFF, 32'sh5555_5555, 32'shAAAA_AAAA, 32'sh7FFF_FFFF};
		send_matrix();

		// identity sits exactly on an epsilon of 65536 (1.0)
		write_epsilon(17'd65536);
		for (int k = 0; k < 16; k++)
			mat[k] = (k % 5 == 0) ? ONE : '0;
		send_matrix();
		run_phase(7, 12, 82);
		write_epsilon(EB'($urandom_range(65536)));
		run_phase(7, 82, 12);
		write_epsilon(17'd1);
		run_phase(7, 0, 0);

		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#20ms;
		$display("Test completed with failures");
		$finish;
	end

endmodule
